@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the contact constraint evaluator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcc assertion failed: same-cycle implication");

// next-cycle implication
`define FCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcc assertion failed: next-cycle implication");

`endif

@@ hdl/fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// fcc_pkg
// Constants, types and helpers of the friction cone constraint evaluator.
// ----------------------------------------------------------------------------
package fcc_pkg;

   localparam int FORCE_FRAC_BITS  = 8;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int MU_FRAC          = 12;
   localparam int DER_FRAC         = 16;

   localparam int FRONT_STAGES = 9;
   localparam int SQ_STAGES    = 32;
   localparam int DIV_QBITS    = 33;
   localparam int DIV_STAGES   = DIV_QBITS + 1;
   localparam int NUM_DIV      = 6;

   localparam logic [15:0] FRICTION_COEFF_RESET   = 16'd4096;
   localparam logic [22:0] NORMAL_FORCE_MIN_RESET = 23'd0;

   typedef enum logic [0:0] {
      CSR_FRICTION_COEFF   = 1'b0,
      CSR_NORMAL_FORCE_MIN = 1'b1
   } fcc_csr_type;

   // front end result, carried through the square root
   typedef struct packed {
      logic [2:0][62:0] mag_u;
      logic [2:0]       neg_u;
      logic [2:0][63:0] mag_v;
      logic [2:0]       neg_v;
      logic [2:0][22:0] mn;
      logic [2:0][28:0] mf;
      logic [31:0]      uni;
      logic [32:0]      m;
      logic             degen;
   } fcc_front_type;

   // values carried through the dividers
   typedef struct packed {
      logic             degen;
      logic [31:0]      cone;
      logic [31:0]      uni;
      logic [2:0][22:0] mn;
      logic [2:0][28:0] mf;
   } fcc_post_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/fcc_if.sv @@
// ----------------------------------------------------------------------------
// fcc_req_if / fcc_rsp_if
// Valid/ready channels of the friction cone constraint evaluator.
// ----------------------------------------------------------------------------
interface fcc_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] force_x;
   logic signed [23:0] force_y;
   logic signed [23:0] force_z;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;

   modport source (output valid, force_x, force_y, force_z, normal_x, normal_y, normal_z,
                   input ready);
   modport sink   (input valid, force_x, force_y, force_z, normal_x, normal_y, normal_z,
                   output ready);
endinterface

interface fcc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] unilateral_value;
   logic signed [31:0] cone_value;
   logic signed [31:0] d_cone_force_x;
   logic signed [31:0] d_cone_force_y;
   logic signed [31:0] d_cone_force_z;
   logic signed [31:0] d_cone_normal_x;
   logic signed [31:0] d_cone_normal_y;
   logic signed [31:0] d_cone_normal_z;
   logic               degenerate;

   modport source (output valid, unilateral_value, cone_value, d_cone_force_x,
                   d_cone_force_y, d_cone_force_z, d_cone_normal_x, d_cone_normal_y,
                   d_cone_normal_z, degenerate, input ready);
   modport sink   (input valid, unilateral_value, cone_value, d_cone_force_x,
                   d_cone_force_y, d_cone_force_z, d_cone_normal_x, d_cone_normal_y,
                   d_cone_normal_z, degenerate, output ready);
endinterface

@@ hdl/fcc_front.sv @@
// ----------------------------------------------------------------------------
// fcc_front
// Nine-stage front end: dot products, tangential force, sums and numerators.
// ----------------------------------------------------------------------------
module fcc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic signed [23:0]    in_force [3],
   input  logic signed [15:0]    in_normal [3],
   input  logic [15:0]           mu,
   input  logic [22:0]           thr,
   output logic                  out_valid,
   output fcc_pkg::fcc_front_type out_data,
   output logic [63:0]           out_sumsq
);
   localparam int NB    = fcc_pkg::NORMAL_FRAC_BITS;
   localparam int MF    = fcc_pkg::MU_FRAC;
   localparam int DF    = fcc_pkg::DER_FRAC;
   localparam int MN_SH = MF + NB - DF;
   localparam int NS    = fcc_pkg::FRONT_STAGES;

   localparam logic signed [40:0] MUF_HALF = 41'sd1 <<< (MF - 1);
   localparam logic signed [32:0] MUN_HALF = 33'sd1 <<< (MN_SH - 1);
   localparam logic signed [43:0] UNI_HALF = 44'sd1 <<< (NB - 1);
   localparam logic signed [57:0] ND_HALF  = 58'sd1 <<< (2 * NB - 1);
   localparam logic signed [58:0] MUD_HALF = 59'sd1 <<< (MF + NB - 1);
   localparam logic signed [41:0] D_HALF   = 42'sd1 <<< (NB - 1);
   localparam logic signed [49:0] P_HALF   = 50'sd1 <<< (NB - 1);
   localparam logic signed [65:0] NP_HALF  = 66'sd1 <<< (2 * NB - 1);

   logic [NS-1:0]      v_ff;
   logic signed [16:0] mus;
   logic signed [43:0] thr_s;

   assign mus   = $signed({1'b0, mu});
   assign thr_s = $signed(44'({thr, {NB{1'b0}}}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end
   assign out_valid = v_ff[NS-1];

   // stage 1: products
   logic signed [23:0] f1_ff [3];
   logic signed [15:0] n1_ff [3];
   logic signed [39:0] fn1_ff [3];
   logic signed [40:0] muf1_ff [3];
   logic signed [32:0] mun1_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            f1_ff[i]   <= in_force[i];
            n1_ff[i]   <= in_normal[i];
            fn1_ff[i]  <= in_force[i] * in_normal[i];
            muf1_ff[i] <= mus * in_force[i];
            mun1_ff[i] <= mus * in_normal[i];
         end
      end
   end

   // stage 2: F.n, rounded mu terms
   logic signed [23:0] f2_ff [3];
   logic signed [15:0] n2_ff [3];
   logic signed [41:0] d2_ff;
   logic signed [28:0] mf2_ff [3];
   logic signed [22:0] mn2_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff <= 42'(fn1_ff[0]) + 42'(fn1_ff[1]) + 42'(fn1_ff[2]);
         for (int i = 0; i < 3; i++) begin
            f2_ff[i]  <= f1_ff[i];
            n2_ff[i]  <= n1_ff[i];
            mf2_ff[i] <= 29'((muf1_ff[i] + MUF_HALF) >>> MF);
            mn2_ff[i] <= 23'((mun1_ff[i] + MUN_HALF) >>> MN_SH);
         end
      end
   end

   // stage 3: n*(F.n), mu*(F.n), unilateral
   logic signed [23:0] f3_ff [3];
   logic signed [15:0] n3_ff [3];
   logic signed [41:0] d3_ff;
   logic signed [57:0] nd3_ff [3];
   logic signed [58:0] mud3_ff;
   logic signed [31:0] uni3_ff;
   logic signed [28:0] mf3_ff [3];
   logic signed [22:0] mn3_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff   <= d2_ff;
         mud3_ff <= mus * d2_ff;
         uni3_ff <= fcc_pkg::sat32(64'((thr_s - 44'(d2_ff) + UNI_HALF) >>> NB));
         for (int i = 0; i < 3; i++) begin
            f3_ff[i]  <= f2_ff[i];
            n3_ff[i]  <= n2_ff[i];
            nd3_ff[i] <= n2_ff[i] * d2_ff;
            mf3_ff[i] <= mf2_ff[i];
            mn3_ff[i] <= mn2_ff[i];
         end
      end
   end

   // stage 4: tangential force t
   logic signed [33:0] nq4 [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nq4[i] = 34'((nd3_ff[i] + ND_HALF) >>> (2 * NB));
      end
   end
   logic signed [23:0] f4_ff [3];
   logic signed [15:0] n4_ff [3];
   logic signed [31:0] t4_ff [3];
   logic signed [32:0] m4_ff;
   logic signed [31:0] dr4_ff;
   logic signed [31:0] uni4_ff;
   logic signed [28:0] mf4_ff [3];
   logic signed [22:0] mn4_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         m4_ff   <= 33'((mud3_ff + MUD_HALF) >>> (MF + NB));
         dr4_ff  <= fcc_pkg::sat32(64'((d3_ff + D_HALF) >>> NB));
         uni4_ff <= uni3_ff;
         for (int i = 0; i < 3; i++) begin
            f4_ff[i]  <= f3_ff[i];
            n4_ff[i]  <= n3_ff[i];
            t4_ff[i]  <= fcc_pkg::sat32(64'(34'(f3_ff[i]) - nq4[i]));
            mf4_ff[i] <= mf3_ff[i];
            mn4_ff[i] <= mn3_ff[i];
         end
      end
   end

   // stage 5: t^2 and n*t
   logic signed [23:0] f5_ff [3];
   logic signed [15:0] n5_ff [3];
   logic signed [31:0] t5_ff [3];
   logic signed [63:0] tt5_ff [3];
   logic signed [47:0] nt5_ff [3];
   logic signed [32:0] m5_ff;
   logic signed [31:0] dr5_ff;
   logic signed [31:0] uni5_ff;
   logic signed [28:0] mf5_ff [3];
   logic signed [22:0] mn5_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         m5_ff   <= m4_ff;
         dr5_ff  <= dr4_ff;
         uni5_ff <= uni4_ff;
         for (int i = 0; i < 3; i++) begin
            f5_ff[i]  <= f4_ff[i];
            n5_ff[i]  <= n4_ff[i];
            t5_ff[i]  <= t4_ff[i];
            tt5_ff[i] <= t4_ff[i] * t4_ff[i];
            nt5_ff[i] <= n4_ff[i] * t4_ff[i];
            mf5_ff[i] <= mf4_ff[i];
            mn5_ff[i] <= mn4_ff[i];
         end
      end
   end

   // stage 6: |t|^2 and n.t
   logic [63:0] sumsq6_in;
   assign sumsq6_in = $unsigned(tt5_ff[0]) + $unsigned(tt5_ff[1]) + $unsigned(tt5_ff[2]);
   logic signed [23:0] f6_ff [3];
   logic signed [15:0] n6_ff [3];
   logic signed [31:0] t6_ff [3];
   logic [63:0]        sumsq6_ff;
   logic               degen6_ff;
   logic signed [49:0] p6_ff;
   logic signed [32:0] m6_ff;
   logic signed [31:0] dr6_ff;
   logic signed [31:0] uni6_ff;
   logic signed [28:0] mf6_ff [3];
   logic signed [22:0] mn6_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         sumsq6_ff <= sumsq6_in;
         degen6_ff <= (sumsq6_in == 64'd0);
         p6_ff     <= 50'(nt5_ff[0]) + 50'(nt5_ff[1]) + 50'(nt5_ff[2]);
         m6_ff     <= m5_ff;
         dr6_ff    <= dr5_ff;
         uni6_ff   <= uni5_ff;
         for (int i = 0; i < 3; i++) begin
            f6_ff[i]  <= f5_ff[i];
            n6_ff[i]  <= n5_ff[i];
            t6_ff[i]  <= t5_ff[i];
            mf6_ff[i] <= mf5_ff[i];
            mn6_ff[i] <= mn5_ff[i];
         end
      end
   end

   // stage 7: n*(n.t), rounded n.t
   logic signed [23:0] f7_ff [3];
   logic signed [31:0] t7_ff [3];
   logic signed [65:0] np7_ff [3];
   logic signed [31:0] pr7_ff;
   logic [63:0]        sumsq7_ff;
   logic               degen7_ff;
   logic signed [32:0] m7_ff;
   logic signed [31:0] dr7_ff;
   logic signed [31:0] uni7_ff;
   logic signed [28:0] mf7_ff [3];
   logic signed [22:0] mn7_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         pr7_ff    <= fcc_pkg::sat32(64'((p6_ff + P_HALF) >>> NB));
         sumsq7_ff <= sumsq6_ff;
         degen7_ff <= degen6_ff;
         m7_ff     <= m6_ff;
         dr7_ff    <= dr6_ff;
         uni7_ff   <= uni6_ff;
         for (int i = 0; i < 3; i++) begin
            f7_ff[i]  <= f6_ff[i];
            t7_ff[i]  <= t6_ff[i];
            np7_ff[i] <= n6_ff[i] * p6_ff;
            mf7_ff[i] <= mf6_ff[i];
            mn7_ff[i] <= mn6_ff[i];
         end
      end
   end

   // stage 8: u and the two products of v
   logic signed [39:0] uq8 [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         uq8[i] = 40'((np7_ff[i] + NP_HALF) >>> (2 * NB));
      end
   end
   logic signed [39:0] u8_ff [3];
   logic signed [63:0] tdr8_ff [3];
   logic signed [55:0] fpr8_ff [3];
   logic [63:0]        sumsq8_ff;
   logic               degen8_ff;
   logic signed [32:0] m8_ff;
   logic signed [31:0] uni8_ff;
   logic signed [28:0] mf8_ff [3];
   logic signed [22:0] mn8_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         sumsq8_ff <= sumsq7_ff;
         degen8_ff <= degen7_ff;
         m8_ff     <= m7_ff;
         uni8_ff   <= uni7_ff;
         for (int i = 0; i < 3; i++) begin
            u8_ff[i]   <= 40'(t7_ff[i]) - uq8[i];
            tdr8_ff[i] <= t7_ff[i] * dr7_ff;
            fpr8_ff[i] <= f7_ff[i] * pr7_ff;
            mf8_ff[i]  <= mf7_ff[i];
            mn8_ff[i]  <= mn7_ff[i];
         end
      end
   end

   // stage 9: sign/magnitude numerators
   logic signed [63:0] v9 [3];
   logic [39:0]        ua9 [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v9[i]  = 64'(tdr8_ff[i]) + 64'(fpr8_ff[i]);
         ua9[i] = u8_ff[i][39] ? 40'(-u8_ff[i]) : 40'(u8_ff[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_sumsq      <= sumsq8_ff;
         out_data.degen <= degen8_ff;
         out_data.m     <= m8_ff;
         out_data.uni   <= uni8_ff;
         for (int i = 0; i < 3; i++) begin
            out_data.neg_u[i] <= u8_ff[i][39];
            out_data.mag_u[i] <= 63'({ua9[i], {DF{1'b0}}});
            out_data.neg_v[i] <= v9[i][63];
            out_data.mag_v[i] <= v9[i][63] ? $unsigned(-v9[i]) : $unsigned(v9[i]);
            out_data.mf[i]    <= mf8_ff[i];
            out_data.mn[i]    <= mn8_ff[i];
         end
      end
   end

endmodule

@@ hdl/fcc_sqrt.sv @@
// ----------------------------------------------------------------------------
// fcc_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module fcc_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [63:0]       in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output logic [SIDE_W-1:0] out_side
);
   localparam int NS = fcc_pkg::SQ_STAGES;

   logic              v_ff    [NS];
   logic [33:0]       rem_ff  [NS];
   logic [31:0]       root_ff [NS];
   logic [63:0]       x_ff    [NS];
   logic [SIDE_W-1:0] side_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic              pv;
      logic [33:0]       prem;
      logic [31:0]       proot;
      logic [63:0]       px;
      logic [SIDE_W-1:0] pside;
      logic [35:0]       rem_sh;
      logic [35:0]       trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign px    = in_rad;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign px    = x_ff[k-1];
         assign pside = side_ff[k-1];
      end

      assign rem_sh = {prem, px[63:62]};
      assign trial  = {2'b00, proot, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_ff[k] <= {proot[30:0], ge};
            x_ff[k]    <= {px[61:0], 2'b00};
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

@@ hdl/fcc_div.sv @@
// ----------------------------------------------------------------------------
// fcc_div
// Six-lane pipelined restoring divider with a shared divisor.
// Quotients clamp to 2^33 in magnitude; each lane saturates on its own.
// ----------------------------------------------------------------------------
module fcc_div #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [63:0]       in_num [fcc_pkg::NUM_DIV],
   input  logic              in_neg [fcc_pkg::NUM_DIV],
   input  logic [31:0]       in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic signed [34:0] out_q [fcc_pkg::NUM_DIV],
   output logic [SIDE_W-1:0] out_side
);
   localparam int NS = fcc_pkg::DIV_STAGES;
   localparam int QB = fcc_pkg::DIV_QBITS;
   localparam int L  = fcc_pkg::NUM_DIV;

   logic              v_ff    [NS];
   logic [31:0]       den_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic [31:0]       rem_ff  [NS][L];
   logic [QB-1:0]     low_ff  [NS][L];
   logic [QB-1:0]     q_ff    [NS][L];
   logic              ovf_ff  [NS][L];
   logic              neg_ff  [NS][L];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      if (k == 0) begin : g_entry
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[0] <= 1'b0;
            end else if (adv) begin
               v_ff[0] <= in_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               den_ff[0]  <= in_den;
               side_ff[0] <= in_side;
               for (int l = 0; l < L; l++) begin
                  ovf_ff[0][l] <= ({1'b0, in_num[l]} >= {in_den, {QB{1'b0}}});
                  rem_ff[0][l] <= 32'(in_num[l][63:QB]);
                  low_ff[0][l] <= in_num[l][QB-1:0];
                  q_ff[0][l]   <= '0;
                  neg_ff[0][l] <= in_neg[l];
               end
            end
         end
      end else begin : g_step
         logic [32:0] rem_sh [L];
         logic        ge     [L];
         always_comb begin
            for (int l = 0; l < L; l++) begin
               rem_sh[l] = {rem_ff[k-1][l], low_ff[k-1][l][QB-1]};
               ge[l]     = (rem_sh[l] >= {1'b0, den_ff[k-1]});
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (adv) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               den_ff[k]  <= den_ff[k-1];
               side_ff[k] <= side_ff[k-1];
               for (int l = 0; l < L; l++) begin
                  rem_ff[k][l] <= ge[l] ? 32'(rem_sh[l] - {1'b0, den_ff[k-1]})
                                        : rem_sh[l][31:0];
                  low_ff[k][l] <= {low_ff[k-1][l][QB-2:0], 1'b0};
                  q_ff[k][l]   <= {q_ff[k-1][l][QB-2:0], ge[l]};
                  ovf_ff[k][l] <= ovf_ff[k-1][l];
                  neg_ff[k][l] <= neg_ff[k-1][l];
               end
            end
         end
      end
   end

   logic signed [34:0] mag [L];
   always_comb begin
      for (int l = 0; l < L; l++) begin
         mag[l]   = ovf_ff[NS-1][l] ? (35'sd1 <<< QB) : $signed(35'(q_ff[NS-1][l]));
         out_q[l] = neg_ff[NS-1][l] ? -mag[l] : mag[l];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

@@ hdl/friction_cone_constraint_eval_unit.sv @@
// ----------------------------------------------------------------------------
// friction_cone_constraint_eval_unit
// Friction cone and unilateral constraint values with the cone Jacobian row.
// ----------------------------------------------------------------------------
//  channel  dir  transfer when            payload
//  req      in   req.valid & req.ready    force_x/y/z Q15.8, normal_x/y/z Q1.14
//  rsp      out  rsp.valid & rsp.ready    values, d_cone_force/normal, degenerate
//  csr      in   csr_we                   csr_index selects register, csr_wdata
//
//  One transfer per cycle in, one per cycle out, unless stalled. The path
//  runs through 9 front stages, 32 square root stages (one root bit each),
//  34 divider stages (entry plus one quotient bit each) and the output register.
//  Synchronous active-high reset clears valid bits and presets the configuration registers.
//  A stall holds the pipeline only when its last stage carries an item and
//  the output register is full and not taken; bubbles are squeezed out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module friction_cone_constraint_eval_unit (
   input  logic        clock,
   input  logic        reset,
   fcc_req_if.sink     req,
   fcc_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [22:0] csr_wdata
);
   localparam int FRONT_W = $bits(fcc_pkg::fcc_front_type);
   localparam int POST_W  = $bits(fcc_pkg::fcc_post_type);
   localparam int L       = fcc_pkg::NUM_DIV;

   // configuration registers
   logic [15:0] mu_ff;
   logic [22:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff  <= fcc_pkg::FRICTION_COEFF_RESET;
         thr_ff <= fcc_pkg::NORMAL_FORCE_MIN_RESET;
      end else if (csr_we) begin
         case (fcc_pkg::fcc_csr_type'(csr_index))
            fcc_pkg::CSR_FRICTION_COEFF:   mu_ff  <= csr_wdata[15:0];
            fcc_pkg::CSR_NORMAL_FORCE_MIN: thr_ff <= csr_wdata;
            default:                       mu_ff  <= mu_ff;
         endcase
      end
   end

   // global advance: whole pipeline moves unless a finished item is blocked
   logic rsp_valid_ff;
   logic out_load;
   logic div_valid;
   logic adv;

   assign out_load  = !(rsp_valid_ff && !rsp.ready);
   assign adv       = !div_valid || out_load;
   assign req.ready = adv;

   // front end
   logic signed [23:0]     in_force [3];
   logic signed [15:0]     in_normal [3];
   logic                   front_valid;
   fcc_pkg::fcc_front_type front_data;
   logic [63:0]            front_sumsq;

   assign in_force[0]  = req.force_x;
   assign in_force[1]  = req.force_y;
   assign in_force[2]  = req.force_z;
   assign in_normal[0] = req.normal_x;
   assign in_normal[1] = req.normal_y;
   assign in_normal[2] = req.normal_z;

   fcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .in_force  (in_force),
      .in_normal (in_normal),
      .mu        (mu_ff),
      .thr       (thr_ff),
      .out_valid (front_valid),
      .out_data  (front_data),
      .out_sumsq (front_sumsq)
   );

   // |t| = floor(sqrt(sum t^2))
   logic                   sq_valid;
   logic [31:0]            sq_root;
   logic [FRONT_W-1:0]     sq_side;
   fcc_pkg::fcc_front_type sq_data;

   fcc_sqrt #(.SIDE_W(FRONT_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_rad    (front_sumsq),
      .in_side   (front_data),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );
   assign sq_data = fcc_pkg::fcc_front_type'(sq_side);

   // rounding bias of half the divisor goes onto each magnitude
   logic [63:0]           div_num [L];
   logic                  div_neg [L];
   fcc_pkg::fcc_post_type post_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_num[i]     = {1'b0, sq_data.mag_u[i]} + 64'(sq_root[31:1]);
         div_num[3 + i] = sq_data.mag_v[i] + 64'(sq_root[31:1]);
         div_neg[i]     = sq_data.neg_u[i];
         div_neg[3 + i] = sq_data.neg_v[i];
      end
      post_in.degen = sq_data.degen;
      post_in.cone  = fcc_pkg::sat32($signed(64'(sq_root)) - 64'($signed(sq_data.m)));
      post_in.uni   = sq_data.uni;
      post_in.mn    = sq_data.mn;
      post_in.mf    = sq_data.mf;
   end

   logic signed [34:0]    div_q [L];
   logic [POST_W-1:0]     div_side;
   fcc_pkg::fcc_post_type post;

   fcc_div #(.SIDE_W(POST_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_num    (div_num),
      .in_neg    (div_neg),
      .in_den    (sq_root),
      .in_side   (post_in),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_side  (div_side)
   );
   assign post = fcc_pkg::fcc_post_type'(div_side);

   // Jacobian row; a zero tangential norm leaves only the mu terms
   logic signed [31:0] jf_in [3];
   logic signed [31:0] jn_in [3];
   logic signed [63:0] mn_s  [3];
   logic signed [63:0] mf_s  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mn_s[i]  = 64'($signed(post.mn[i]));
         mf_s[i]  = 64'($signed(post.mf[i]));
         jf_in[i] = fcc_pkg::sat32(post.degen ? -mn_s[i] : 64'(div_q[i]) - mn_s[i]);
         jn_in[i] = fcc_pkg::sat32(post.degen ? -mf_s[i] : -64'(div_q[3 + i]) - mf_s[i]);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp.unilateral_value <= post.uni;
         rsp.cone_value       <= post.cone;
         rsp.d_cone_force_x   <= jf_in[0];
         rsp.d_cone_force_y   <= jf_in[1];
         rsp.d_cone_force_z   <= jf_in[2];
         rsp.d_cone_normal_x  <= jn_in[0];
         rsp.d_cone_normal_y  <= jn_in[1];
         rsp.d_cone_normal_z  <= jn_in[2];
         rsp.degenerate       <= post.degen;
      end
   end
   assign rsp.valid = rsp_valid_ff;

   // input is refused only while a finished result waits at the output
   `FCC_ASSERT_NOW(a_ready_low_only_on_held_result, clock, reset, !req.ready, rsp.valid && !rsp.ready)
   // reset empties the output register
   `FCC_ASSERT_NEXT(a_reset_clears_output, clock, 1'b0, reset, !rsp.valid)
   // a transfer out with nothing behind it leaves the output empty
   `FCC_ASSERT_NEXT(a_drain_empties_output, clock, reset, rsp.valid && rsp.ready && !div_valid, !rsp.valid)

endmodule

@@ bench/tb_friction_cone_constraint_eval_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_friction_cone_constraint_eval_unit
// Streams contact force / normal pairs through the evaluator under random
// sender bursts and receiver stalls. Each response is checked field by field
// against hand-written values or a cycle-free fixed-point predictor of the cone
// and unilateral terms and Jacobian row, over several friction / threshold settings.
// ----------------------------------------------------------------------------
module tb_friction_cone_constraint_eval_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 100;   // longer than the pipeline latency
   localparam int RANDOM_ITEMS   = 110;   // per setting, four settings

   typedef struct {
      logic signed [23:0] fx, fy, fz;
      logic signed [15:0] nx, ny, nz;
   } contact_type;

   typedef struct {
      logic signed [31:0] uni, cone;
      logic signed [31:0] dfx, dfy, dfz;
      logic signed [31:0] dnx, dny, dnz;
      logic               degen;
   } cone_row_type;

   typedef struct {
      contact_type  c;
      bit           typed;   // expected values written out by hand
      cone_row_type exp;
   } stim_row_type;

   logic clock;
   logic reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [22:0] csr_wdata;

   fcc_req_if req ();
   fcc_rsp_if rsp ();

   friction_cone_constraint_eval_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the two registers
   logic [15:0] mu_q412;
   logic [22:0] force_floor;

   cone_row_type pending_rows[$];
   stim_row_type dir_rows[$];
   int           errors;
   int           idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint round_shift(longint x, int sh);
      if (sh == 0) begin
         return x;
      end
      return (x + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint clamp32(longint x);
      return clamp(x, -longint'(64'sd2147483648), 64'sd2147483647);
   endfunction

   // rounds half away from zero, quotient takes the numerator's sign
   function automatic longint div_round(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : num;
      q   = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic cone_row_type predict_cone_row(contact_type c);
      longint f[3], n[3], t[3];
      longint d, p, dr, pr, m, mu, thr, q, u, v, mn, mf, jf, jn;
      longint unsigned sumsq, tnorm;
      logic [2:0][31:0] jfs, jns;
      cone_row_type r;
      f = '{c.fx, c.fy, c.fz};
      n = '{c.nx, c.ny, c.nz};
      mu  = mu_q412;
      thr = longint'(force_floor) <<< fcc_pkg::NORMAL_FRAC_BITS;
      d = 0;
      p = 0;
      sumsq = 0;
      for (int i = 0; i < 3; i++) d += f[i] * n[i];
      // tangential part, then its projection on n
      for (int i = 0; i < 3; i++) begin
         q = round_shift(n[i] * d, 2 * fcc_pkg::NORMAL_FRAC_BITS);
         t[i] = clamp32(f[i] - q);
         sumsq += longint'(t[i] * t[i]);
         p += n[i] * t[i];
      end
      tnorm   = floor_sqrt(sumsq);
      r.degen = (sumsq == 0);
      r.uni   = clamp32(round_shift(thr - d, fcc_pkg::NORMAL_FRAC_BITS));
      m       = round_shift(mu * d, fcc_pkg::MU_FRAC + fcc_pkg::NORMAL_FRAC_BITS);
      r.cone  = clamp32(longint'(tnorm) - m);
      dr = clamp32(round_shift(d, fcc_pkg::NORMAL_FRAC_BITS));
      pr = clamp32(round_shift(p, fcc_pkg::NORMAL_FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
         mn = round_shift(mu * n[i],
                          fcc_pkg::MU_FRAC + fcc_pkg::NORMAL_FRAC_BITS - fcc_pkg::DER_FRAC);
         mf = round_shift(mu * f[i], fcc_pkg::MU_FRAC);
         if (r.degen) begin
            jf = -mn;
            jn = -mf;
         end else begin
            q  = round_shift(n[i] * p, 2 * fcc_pkg::NORMAL_FRAC_BITS);
            u  = clamp(t[i] - q, -(longint'(1) <<< 46), (longint'(1) <<< 46) - 1);
            v  = t[i] * dr + f[i] * pr;
            jf = div_round(u * 65536, tnorm) - mn;
            jn = -div_round(v, tnorm) - mf;
         end
         jfs[i] = clamp32(jf);
         jns[i] = clamp32(jn);
      end
      r.dfx = jfs[0];
      r.dfy = jfs[1];
      r.dfz = jfs[2];
      r.dnx = jns[0];
      r.dny = jns[1];
      r.dnz = jns[2];
      return r;
   endfunction

   // ------------------------------------------------------------------ checker
   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0d, got %0d", name, $signed(exp), $signed(act));
         errors++;
      end
   endtask

   always @(posedge clock) begin
      cone_row_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rows.size() == 0) begin
            $error("response transfer with nothing outstanding");
            errors++;
         end else begin
            e = pending_rows.pop_front();
            check_field("unilateral_value", e.uni, rsp.unilateral_value);
            check_field("cone_value", e.cone, rsp.cone_value);
            check_field("d_cone_force_x", e.dfx, rsp.d_cone_force_x);
            check_field("d_cone_force_y", e.dfy, rsp.d_cone_force_y);
            check_field("d_cone_force_z", e.dfz, rsp.d_cone_force_z);
            check_field("d_cone_normal_x", e.dnx, rsp.d_cone_normal_x);
            check_field("d_cone_normal_y", e.dny, rsp.d_cone_normal_y);
            check_field("d_cone_normal_z", e.dnz, rsp.d_cone_normal_z);
            check_field("degenerate", 32'(e.degen), 32'(rsp.degenerate));
         end
      end
   end

   // ---------------------------------------------------------- receiver stalls
   // every mode pick is random: always ready, coin flip, or a repeating stall pattern
   int unsigned rx_mode, rx_count;
   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      if (rx_count % 64 == 0) rx_mode = $urandom_range(2, 0);
      rx_count++;
      case (rx_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= $urandom_range(1, 0);
         default: rsp.ready <= (rx_count % 7) >= 3;
      endcase
   end

   // ----------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------ sender
   int burst_left;

   // holds valid until the transfer, queues the expectation on acceptance
   task automatic send_contact(contact_type c, bit typed, cone_row_type exp);
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(20, 1);
      end
      burst_left--;
      req.valid    <= 1'b1;
      req.force_x  <= c.fx;
      req.force_y  <= c.fy;
      req.force_z  <= c.fz;
      req.normal_x <= c.nx;
      req.normal_y <= c.ny;
      req.normal_z <= c.nz;
      do @(posedge clock); while (!req.ready);
      pending_rows.push_back(typed ? exp : predict_cone_row(c));
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(fcc_pkg::fcc_csr_type idx, logic [22:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == fcc_pkg::CSR_FRICTION_COEFF) mu_q412 = value[15:0];
      else force_floor = value;
      @(posedge clock);
   endtask

   function automatic void add_row(int fx, int fy, int fz, int nx, int ny, int nz);
      stim_row_type r;
      r.c     = '{fx, fy, fz, nx, ny, nz};
      r.typed = 1'b0;
      r.exp   = '{default: '0};
      dir_rows.push_back(r);
   endfunction

   function automatic contact_type random_contact();
      contact_type c;
      int unsigned kind;
      int mag;
      kind = $urandom_range(9, 0);
      c = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      case (kind)
         0, 1, 2: ;  // full range noise
         3, 4: begin  // small forces, near-unit normals
            mag  = $urandom_range(4096, 1);
            c.fx = $signed($urandom_range(2 * mag, 0)) - mag;
            c.fy = $signed($urandom_range(2 * mag, 0)) - mag;
            c.fz = $signed($urandom_range(2 * mag, 0));
            c.nx = $signed($urandom_range(8000, 0)) - 4000;
            c.ny = $signed($urandom_range(8000, 0)) - 4000;
            c.nz = $signed($urandom_range(16384, 14000));
         end
         5: begin  // force along an axis normal: no tangential part
            c.nx = 0;
            c.ny = 0;
            c.nz = $urandom_range(1, 0) ? 16384 : -16384;
            c.fx = 0;
            c.fy = 0;
         end
         6: begin  // axis normal in x
            c.nx = $urandom_range(1, 0) ? 16384 : -16384;
            c.ny = 0;
            c.nz = 0;
            c.fy = $signed($urandom_range(4, 0)) - 2;
            c.fz = $signed($urandom_range(4, 0)) - 2;
         end
         7: begin  // tiny tangential magnitude
            c.fx = $signed($urandom_range(6, 0)) - 3;
            c.fy = $signed($urandom_range(6, 0)) - 3;
            c.fz = $signed($urandom_range(65536, 0)) - 32768;
            c.nx = $signed($urandom_range(6, 0)) - 3;
            c.ny = $signed($urandom_range(6, 0)) - 3;
            c.nz = 16384;
         end
         default: begin  // moderate normals, wide forces
            c.nx = $signed($urandom_range(32768, 0)) - 16384;
            c.ny = $signed($urandom_range(32768, 0)) - 16384;
            c.nz = $signed($urandom_range(32768, 0)) - 16384;
         end
      endcase
      return c;
   endfunction

   task automatic run_random(int count);
      cone_row_type none;
      none = '{default: '0};
      repeat (count) send_contact(random_contact(), 1'b0, none);
   endtask

   // --------------------------------------------------------------- main flow
   initial begin
      stim_row_type r;
      cone_row_type none;
      errors      = 0;
      burst_left  = 0;
      rx_count    = 0;
      rx_mode     = 0;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = fcc_pkg::CSR_FRICTION_COEFF;
      csr_wdata   = '0;
      req.valid   = 1'b0;
      req.force_x = '0;
      req.force_y = '0;
      req.force_z = '0;
      req.normal_x = '0;
      req.normal_y = '0;
      req.normal_z = '0;
      mu_q412     = fcc_pkg::FRICTION_COEFF_RESET;
      force_floor = fcc_pkg::NORMAL_FORCE_MIN_RESET;
      none        = '{default: '0};

      // all zero after reset: degenerate, everything else zero
      r.c = '{0, 0, 0, 0, 0, 0};
      r.typed = 1'b1;
      r.exp = '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1};
      dir_rows.push_back(r);
      // one unit along the unit z normal, mu = 1: purely normal, degenerate
      r.c = '{0, 0, 256, 0, 0, 16384};
      r.exp = '{-256, -256, 0, 0, -65536, 0, 0, -256, 1'b1};
      dir_rows.push_back(r);
      // force extremes against a zero normal
      add_row(8388607, -8388608, 8388607, 0, 0, 0);
      add_row(-8388608, 8388607, -8388608, 0, 0, 0);
      // normal extremes
      add_row(256, 256, 256, 32767, 32767, 32767);
      add_row(256, -256, 256, -32768, -32768, -32768);
      add_row(8388607, 8388607, 8388607, 32767, 32767, 32767);
      add_row(-8388608, -8388608, -8388608, -32768, -32768, -32768);
      add_row(8388607, -8388608, 8388607, -32768, 32767, -32768);
      // tangential only, and tangential plus normal
      add_row(256, 0, 0, 0, 0, 16384);
      add_row(300, -400, 1000, 0, 0, 16384);
      add_row(-1, 1, 5000, 0, 0, 16384);
      add_row(1000, 2000, -3000, 9459, 9459, 9459);
      add_row(0, 0, -8388608, 0, 0, -16384);
      add_row(77, -5, 123456, 120, -300, 16380);

      @(posedge clock);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_contact(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].exp);
      run_random(RANDOM_ITEMS);

      // sender pauses until the pipe is empty before each register change
      drain_results();
      write_csr(fcc_pkg::CSR_FRICTION_COEFF, 23'd0);
      write_csr(fcc_pkg::CSR_NORMAL_FORCE_MIN, 23'h7F_FFFF);
      foreach (dir_rows[i]) if (!dir_rows[i].typed) send_contact(dir_rows[i].c, 1'b0, none);
      run_random(RANDOM_ITEMS);

      drain_results();
      // upper bits beyond the 16 bit register are dropped
      write_csr(fcc_pkg::CSR_FRICTION_COEFF, 23'h7F_FFFF);
      write_csr(fcc_pkg::CSR_NORMAL_FORCE_MIN, 23'd0);
      run_random(RANDOM_ITEMS);

      drain_results();
      write_csr(fcc_pkg::CSR_FRICTION_COEFF, 23'($urandom));
      write_csr(fcc_pkg::CSR_NORMAL_FORCE_MIN, 23'($urandom));
      run_random(RANDOM_ITEMS);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("SUCCESS");
      end else begin
         if (pending_rows.size() != 0) $error("%0d results never came", pending_rows.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
